### design/swm_pkg.sv
// Package for the sliding-window median filter: widths, defaults, register map,
// item kinds and the sequencer state type. No dependencies.
`default_nettype none

package swm_pkg;

    // Default sizing, handed to the top level as parameter defaults
    localparam int MAX_WINDOW_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int WS_W    = 7;   // window length register
    localparam int COUNT_W = 7;   // valid_count result field

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [WS_W-1:0] WS_RESET = 7'd5;

    // Register index (paddr[PADDR_W-1:2])
    localparam logic REG_WIN_LEN = 1'b0;

    // Item kinds
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OLD,
        ST_MERGE,
        ST_DONE
    } swm_state_t;

endpackage

`default_nettype wire

### design/swm_in_if.sv
// Input channel of the sliding-window median filter: valid/ready plus one item.
// Depends on swm_pkg for the default sample width.
`default_nettype none

interface swm_in_if #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output kind, output sample, input ready);
    modport sink   (input valid, input kind, input sample, output ready);
endinterface

`default_nettype wire

### design/swm_out_if.sv
// Result channel of the sliding-window median filter: valid/ready plus one result.
// Depends on swm_pkg for widths.
`default_nettype none

interface swm_out_if #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
    logic                               valid;
    logic                               ready;
    logic signed [SAMPLE_WIDTH-1:0]     median;
    logic [swm_pkg::COUNT_W-1:0]        valid_count;

    modport source (output valid, output median, output valid_count, input ready);
    modport sink   (input valid, input median, input valid_count, output ready);
endinterface

`default_nettype wire

### design/sliding_window_median.sv
// Sliding-window median filter. A sample beat goes from acceptance through ST_OLD,
// ST_MERGE (one pass over the n entries held before it, 0..MAX_WINDOW, in the
// sorted-list memory, one entry a cycle) and ST_DONE (waits for a free result slot)
// to the result register. A restart beat gives no result. The input is ready only in
// idle, so no new beat is taken while a sample is in flight. rst_n clears control state
// at once and loads the window length register with 5; both memories keep their contents.
`default_nettype none

module sliding_window_median #(
    parameter int MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [swm_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [swm_pkg::PDATA_W-1:0]   pwdata,
    output logic      [swm_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    // item channels
    swm_in_if.sink                             sample_ch,
    swm_out_if.source                          result_ch
);

    // AW addresses one window entry; CW holds a count up to MAX_WINDOW.
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int EW = (CW > swm_pkg::WS_W) ? CW : swm_pkg::WS_W;
    localparam logic [EW-1:0] MAX_EXT = EW'(MAX_WINDOW);

    // ------------------------------------------------------------------
    // Architecture
    //   win RAM    : circular window, entry write_position gets each sample.
    //   sort RAM   : the same samples kept in ascending signed order,
    //                entries 0..n-1 valid, n derived from position/full.
    // For each sample beat the sequencer reads the evicted sample (only
    // meaningful once the window is full), writes the new one, then streams
    // the sorted list once: drop the first entry equal to the evicted value,
    // insert the new sample ahead of the first larger entry, and write the
    // result back in place. Writes never run ahead of reads (read-first RAM,
    // at most one write per cycle, a one-entry hold buffer absorbs the
    // extra element of an insertion). The entry landing at index count/2 is
    // captured as the median on the fly.
    // ------------------------------------------------------------------

    swm_pkg::swm_state_t state_reg, state_next;

    logic [swm_pkg::WS_W-1:0]      ws_reg;
    logic [AW-1:0]                 pos_reg, pos_next;
    logic                          full_reg, full_next;

    logic signed [SAMPLE_WIDTH-1:0] new_reg;
    logic signed [SAMPLE_WIDTH-1:0] old_reg;
    logic signed [SAMPLE_WIDTH-1:0] hold_reg, hold_next;
    logic                           hold_v_reg, hold_v_next;
    logic                           ins_done_reg, ins_done_next;
    logic                           rem_done_reg, rem_done_next;
    logic [CW-1:0]                  idx_reg, idx_next;
    logic [CW-1:0]                  wr_idx_reg, wr_idx_next;
    logic signed [SAMPLE_WIDTH-1:0] med_reg;

    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_med_reg;
    logic [swm_pkg::COUNT_W-1:0]    out_cnt_reg;

    // RAM ports
    logic [SAMPLE_WIDTH-1:0] win_rdata;
    logic [SAMPLE_WIDTH-1:0] sort_rdata;
    logic                    win_we;
    logic                    sort_we;
    logic [SAMPLE_WIDTH-1:0] sort_wdata;
    logic [AW-1:0]           sort_raddr;

    // Handshakes
    logic in_accept;
    logic out_take;
    logic slot_free;
    logic cfg_write;
    logic load_out;

    // Sizes and counts
    logic [EW-1:0] ws_ext;
    logic [CW-1:0] size_eff;
    logic [CW-1:0] pos_ext;
    logic [CW-1:0] pos_inc;
    logic [CW-1:0] n_old;
    logic [CW-1:0] cnt_new;
    logic [CW-1:0] half;
    logic [CW-1:0] idx_inc;

    // Stream decisions for the current sorted entry
    logic signed [SAMPLE_WIDTH-1:0] cur;
    logic is_rem;
    logic is_ins;
    logic keep;

    // ------------------------------------------------------------------
    // Sizes: a zero window acts as one, an oversize window as MAX_WINDOW.
    // ------------------------------------------------------------------
    assign ws_ext   = EW'(ws_reg);
    assign size_eff = (ws_ext == '0)     ? CW'(1) :
                      (ws_ext > MAX_EXT) ? CW'(MAX_WINDOW) : CW'(ws_ext);
    assign pos_ext  = CW'(pos_reg);
    assign pos_inc  = pos_ext + CW'(1);
    assign n_old    = full_reg ? size_eff : pos_ext;
    assign cnt_new  = full_reg ? size_eff : pos_inc;
    assign half     = cnt_new >> 1;
    assign idx_inc  = idx_reg + CW'(1);

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign sample_ch.ready = (state_reg == swm_pkg::ST_IDLE);
    assign in_accept       = sample_ch.valid && sample_ch.ready;
    assign out_take        = result_ch.valid && result_ch.ready;
    assign slot_free       = !out_valid_reg || result_ch.ready;

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.median      = out_med_reg;
    assign result_ch.valid_count = out_cnt_reg;

    // Configuration: one register, decoded on the word index only.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[swm_pkg::PADDR_W-1:2] == swm_pkg::REG_WIN_LEN);

    always_comb
    begin
        prdata = '0;
        if (paddr[swm_pkg::PADDR_W-1:2] == swm_pkg::REG_WIN_LEN)
        begin
            prdata = swm_pkg::PDATA_W'(ws_reg);
        end
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    swm_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_win_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr (pos_reg),
        .wdata (new_reg),
        .raddr (pos_reg),
        .rdata (win_rdata)
    );

    swm_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_sort_ram (
        .clk   (clk),
        .we    (sort_we),
        .waddr (wr_idx_reg[AW-1:0]),
        .wdata (sort_wdata),
        .raddr (sort_raddr),
        .rdata (sort_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swm_pkg::ST_IDLE:
            begin
                if (in_accept && (sample_ch.kind == swm_pkg::KIND_SAMPLE))
                begin
                    state_next = swm_pkg::ST_OLD;
                end
            end
            swm_pkg::ST_OLD:
            begin
                state_next = swm_pkg::ST_MERGE;
            end
            swm_pkg::ST_MERGE:
            begin
                if (idx_reg == n_old)
                begin
                    state_next = swm_pkg::ST_DONE;
                end
            end
            swm_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = swm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swm_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs and the merge stream
    // ------------------------------------------------------------------
    assign cur    = $signed(sort_rdata);
    assign is_rem = full_reg && !rem_done_reg && (cur == old_reg);
    assign is_ins = !ins_done_reg && (new_reg < cur);
    assign keep   = !is_rem;

    always_comb
    begin
        win_we        = 1'b0;
        sort_we       = 1'b0;
        sort_wdata    = hold_reg;
        sort_raddr    = '0;
        hold_next     = hold_reg;
        hold_v_next   = hold_v_reg;
        ins_done_next = ins_done_reg;
        rem_done_next = rem_done_reg;
        idx_next      = idx_reg;
        wr_idx_next   = wr_idx_reg;
        load_out      = 1'b0;
        pos_next      = pos_reg;
        full_next     = full_reg;

        unique case (state_reg)
            swm_pkg::ST_IDLE:
            begin
                // restart beat: drop position and fill flag, nothing else
                if (in_accept && (sample_ch.kind == swm_pkg::KIND_RESTART))
                begin
                    pos_next  = '0;
                    full_next = 1'b0;
                end
            end
            swm_pkg::ST_OLD:
            begin
                // evicted sample is on win_rdata; overwrite it, start the stream
                win_we        = 1'b1;
                sort_raddr    = '0;
                hold_v_next   = 1'b0;
                ins_done_next = 1'b0;
                rem_done_next = 1'b0;
                idx_next      = '0;
                wr_idx_next   = '0;
            end
            swm_pkg::ST_MERGE:
            begin
                sort_raddr = idx_inc[AW-1:0];
                if (idx_reg != n_old)
                begin
                    idx_next = idx_inc;
                    if (is_rem)
                    begin
                        rem_done_next = 1'b1;
                    end
                    if (is_ins)
                    begin
                        ins_done_next = 1'b1;
                    end
                    if (hold_v_reg)
                    begin
                        // hold implies the insertion is done: at most one candidate
                        sort_we     = 1'b1;
                        sort_wdata  = hold_reg;
                        hold_v_next = keep;
                        hold_next   = cur;
                    end
                    else if (is_ins)
                    begin
                        sort_we     = 1'b1;
                        sort_wdata  = new_reg;
                        hold_v_next = keep;
                        hold_next   = cur;
                    end
                    else if (keep)
                    begin
                        sort_we    = 1'b1;
                        sort_wdata = cur;
                    end
                end
                else
                begin
                    // end of list: flush the hold entry or append the new sample
                    if (hold_v_reg)
                    begin
                        sort_we     = 1'b1;
                        sort_wdata  = hold_reg;
                        hold_v_next = 1'b0;
                    end
                    else if (!ins_done_reg)
                    begin
                        sort_we       = 1'b1;
                        sort_wdata    = new_reg;
                        ins_done_next = 1'b1;
                    end
                end
                if (sort_we)
                begin
                    wr_idx_next = wr_idx_reg + CW'(1);
                end
            end
            swm_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    load_out = 1'b1;
                    if (pos_inc >= size_eff)
                    begin
                        pos_next  = '0;
                        full_next = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_inc[AW-1:0];
                    end
                end
            end
            default:
            begin
                win_we = 1'b0;
            end
        endcase

        // a window size write restarts the filter
        if (cfg_write)
        begin
            pos_next  = '0;
            full_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swm_pkg::ST_IDLE;
            ws_reg        <= swm_pkg::WS_RESET;
            pos_reg       <= '0;
            full_reg      <= 1'b0;
            hold_v_reg    <= 1'b0;
            ins_done_reg  <= 1'b0;
            rem_done_reg  <= 1'b0;
            idx_reg       <= '0;
            wr_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            full_reg     <= full_next;
            hold_v_reg   <= hold_v_next;
            ins_done_reg <= ins_done_next;
            rem_done_reg <= rem_done_next;
            idx_reg      <= idx_next;
            wr_idx_reg   <= wr_idx_next;
            if (cfg_write)
            begin
                ws_reg <= pwdata[swm_pkg::WS_W-1:0];
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        if (in_accept)
        begin
            new_reg <= sample_ch.sample;
        end
        if (state_reg == swm_pkg::ST_OLD)
        begin
            old_reg <= $signed(win_rdata);
        end
        // catch the entry landing at rank count/2
        if (sort_we && (wr_idx_reg == half))
        begin
            med_reg <= $signed(sort_wdata);
        end
        if (load_out)
        begin
            out_med_reg <= med_reg;
            out_cnt_reg <= swm_pkg::COUNT_W'(cnt_new);
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_hold_after_insert: assert property (@(posedge clk) disable iff (!rst_n)
        hold_v_reg |-> ins_done_reg)
        else $error("hold buffer occupied before the new sample was inserted");

    a_write_behind_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == swm_pkg::ST_MERGE) |-> (wr_idx_reg <= idx_reg))
        else $error("sorted list write overtook the read pointer");

    a_list_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == swm_pkg::ST_DONE) |-> (wr_idx_reg == cnt_new))
        else $error("sorted list length mismatch after merge");

    a_evicted_found: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == swm_pkg::ST_DONE) && full_reg) |-> rem_done_reg)
        else $error("evicted sample not found in sorted list");

    a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != swm_pkg::ST_IDLE) |-> (pos_ext < size_eff))
        else $error("write position outside the window");

endmodule

`default_nettype wire

### design/swm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read-first on a same-address collision. No dependencies.
`default_nettype none

module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
